>>> design/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg: shared types for the order book level aggregator
// Command and status codes, the level-cell broadcast and wave words, the order
// table entry and the controller states.
// ----------------------------------------------------------------------------
package lob_pkg;

    localparam logic signed [47:0] VOL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic SIDE_BID = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ORDER_FULL = 2'd1,
        ST_LEVEL_FULL = 2'd2
    } t_status;

    // Operation that a wave performs as it passes through the level cells.
    typedef enum logic [1:0] {
        WOP_PROBE = 2'd0,
        WOP_SET   = 2'd1,
        WOP_ALLOC = 2'd2
    } t_wop;

    // Held steady by the controller for the whole of a wave.
    typedef struct packed {
        t_wop               op;
        logic               side;
        logic signed [31:0] price;
        logic signed [47:0] vol;
        logic               kill;
    } t_lv_cmd;

    // Word handed from one level cell to the next in every cycle.
    typedef struct packed {
        logic               go;
        logic               claim;
        logic               have_bid;
        logic signed [31:0] top_bid;
        logic               have_ask;
        logic signed [31:0] low_ask;
        logic               hit;
        logic signed [47:0] vol;
        logic               free;
    } t_wave;

    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic signed [31:0] price;
        logic [31:0]        qty;
    } t_order;

    typedef enum logic [1:0] {
        PH_ADD     = 2'd0,
        PH_CANCEL  = 2'd1,
        PH_MOD_SUB = 2'd2,
        PH_MOD_ADD = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_DECIDE,
        S_LAUNCH,
        S_WAIT,
        S_PC1_RET,
        S_PC2_RET,
        S_LA_START,
        S_LA_PROBED,
        S_LA_FIN,
        S_WRITE,
        S_OUT_START,
        S_DONE
    } t_state;

endpackage

>>> design/limit_order_book_levels.sv
// A query runs a single probe wave from acceptance to result; other words
// scan the order table, then run their waves through the level cells, up to
// seven waves for a known modify.
// Words are taken one at a time; the order-table scan over the single RAM
// read port and the waves through the level-cell row hold off the next word.
// Reset: level tables empty at once; a clearing pass then empties the order
// table, during which no word is accepted.
// ----------------------------------------------------------------------------
// limit_order_book_levels: order book price-level aggregation
// Order table in RAM, scanned per non-query word; bid and ask level tables in
// a row of cells that lookup, update, allocation and best-price waves cross.
// ----------------------------------------------------------------------------
module limit_order_book_levels #(
    parameter int ORDER_SLOTS  = 1024,
    parameter int PRICE_LEVELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [63:0]        i_order_key,
    input  logic signed [31:0] i_price,
    input  logic [31:0]        i_quantity,
    input  logic               i_side,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_best_bid_price,
    output logic signed [31:0] o_best_ask_price,
    output logic signed [47:0] o_level_volume,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(ORDER_SLOTS);
    localparam logic [AW-1:0] LAST = AW'(ORDER_SLOTS - 1);
    localparam int OW = $bits(lob_pkg::t_order);

    lob_pkg::t_state    r_state;
    lob_pkg::t_state    n_state;
    lob_pkg::t_state    r_ret;

    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_pidx;
    logic               r_pend;

    lob_pkg::t_cmd      r_cmd;
    logic [63:0]        r_key;
    logic signed [31:0] r_price;
    logic [31:0]        r_qty;
    logic               r_side;
    lob_pkg::t_status   r_status;

    logic               r_found;
    logic               r_free_found;
    logic [AW-1:0]      r_midx;
    logic [AW-1:0]      r_fidx;
    logic [AW-1:0]      r_slot;
    logic signed [31:0] r_old_price;
    logic [31:0]        r_old_qty;
    logic               r_hn;
    logic               r_fr;

    logic signed [31:0] r_lp;
    logic signed [32:0] r_ld;
    lob_pkg::t_phase    r_phase;

    lob_pkg::t_wop      r_wop;
    logic signed [31:0] r_wprice;
    logic               r_wside;
    logic signed [47:0] r_wvol;
    logic               r_wkill;
    lob_pkg::t_wave     r_res;

    logic [AW-1:0]      r_wr_addr;
    lob_pkg::t_order    r_wr_data;

    logic               r_o_valid;
    logic signed [31:0] r_o_bb;
    logic signed [31:0] r_o_ba;
    logic signed [47:0] r_o_vol;
    lob_pkg::t_status   r_o_status;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [OW-1:0]      ram_wdata;
    logic [OW-1:0]      ram_rdata;
    lob_pkg::t_order    rd;

    logic               launch;
    lob_pkg::t_lv_cmd   lv_cmd;
    lob_pkg::t_wave     w [PRICE_LEVELS+1];
    lob_pkg::t_wave     w_last;

    logic               dec_add;
    logic               dec_full;
    logic signed [48:0] la_sum;
    logic               la_kill;
    logic signed [47:0] la_satv;
    logic               ld_pos;
    logic signed [48:0] old_left;
    logic               freed_old;
    logic               new_present;
    logic               mod_fail;
    logic               out_free;

    // Order table.
    lob_ram #(
        .WIDTH (OW),
        .DEPTH (ORDER_SLOTS)
    ) u_orders (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd = lob_pkg::t_order'(ram_rdata);

    // Row of level cells; a wave enters at cell zero and leaves at the far end.
    assign lv_cmd = '{op: r_wop, side: r_wside, price: r_wprice, vol: r_wvol, kill: r_wkill};

    always_comb begin
        w[0]          = '0;
        w[0].go       = launch;
        w[0].claim    = 1'b1;
    end

    for (genvar g = 0; g < PRICE_LEVELS; g++) begin : g_cell
        lob_level_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lv_cmd),
            .i_wave  (w[g]),
            .o_wave  (w[g+1])
        );
    end

    assign w_last = w[PRICE_LEVELS];

    // Level update arithmetic and modify pre-check.
    always_comb begin
        dec_add     = (r_cmd == lob_pkg::CMD_ADD) || ((r_cmd == lob_pkg::CMD_MODIFY) && !r_found);
        dec_full    = !r_found && !r_free_found;
        la_sum      = {r_res.vol[47], r_res.vol} + {{16{r_ld[32]}}, r_ld};
        la_kill     = la_sum[48] || (la_sum == '0);
        la_satv     = (!la_sum[48] && la_sum[47]) ? lob_pkg::VOL_MAX : la_sum[47:0];
        ld_pos      = !r_ld[32] && (r_ld != '0);
        old_left    = {r_res.vol[47], r_res.vol} - {17'b0, r_old_qty};
        freed_old   = r_res.hit && (old_left[48] || (old_left == '0));
        new_present = r_hn && !((r_old_price == r_price) && freed_old);
        mod_fail    = (r_qty != '0) && !new_present && !(r_fr || freed_old);
        out_free    = !r_o_valid || !i_out_stall;
    end

    // Controller state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lob_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, RAM write port and wave launch.
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = r_wr_data;
        launch    = 1'b0;
        case (r_state)
            lob_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = '0;
                if (r_addr == LAST) begin
                    n_state = lob_pkg::S_IDLE;
                end
            end
            lob_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (lob_pkg::t_cmd'(i_command) == lob_pkg::CMD_QUERY) begin
                        n_state = lob_pkg::S_OUT_START;
                    end else begin
                        n_state = lob_pkg::S_SCAN;
                    end
                end
            end
            lob_pkg::S_SCAN: begin
                if (r_addr == LAST) begin
                    n_state = lob_pkg::S_SCAN_LAST;
                end
            end
            lob_pkg::S_SCAN_LAST: begin
                n_state = lob_pkg::S_DECIDE;
            end
            lob_pkg::S_DECIDE: begin
                if (r_cmd == lob_pkg::CMD_CANCEL) begin
                    n_state = lob_pkg::S_LA_START;
                end else if (dec_add) begin
                    n_state = dec_full ? lob_pkg::S_OUT_START : lob_pkg::S_LA_START;
                end else if (r_cmd == lob_pkg::CMD_MODIFY) begin
                    n_state = lob_pkg::S_LAUNCH;
                end else begin
                    n_state = lob_pkg::S_OUT_START;
                end
            end
            lob_pkg::S_LAUNCH: begin
                launch  = 1'b1;
                n_state = lob_pkg::S_WAIT;
            end
            lob_pkg::S_WAIT: begin
                if (w_last.go) begin
                    n_state = r_ret;
                end
            end
            lob_pkg::S_PC1_RET: begin
                n_state = lob_pkg::S_LAUNCH;
            end
            lob_pkg::S_PC2_RET: begin
                n_state = mod_fail ? lob_pkg::S_OUT_START : lob_pkg::S_LA_START;
            end
            lob_pkg::S_LA_START: begin
                n_state = lob_pkg::S_LAUNCH;
            end
            lob_pkg::S_LA_PROBED: begin
                if (r_res.hit || (ld_pos && r_res.free)) begin
                    n_state = lob_pkg::S_LAUNCH;
                end else if (!ld_pos) begin
                    n_state = lob_pkg::S_LA_FIN;
                end else begin
                    n_state = lob_pkg::S_OUT_START;
                end
            end
            lob_pkg::S_LA_FIN: begin
                if (r_phase == lob_pkg::PH_MOD_SUB) begin
                    n_state = lob_pkg::S_LA_START;
                end else if ((r_phase == lob_pkg::PH_CANCEL) && !r_found) begin
                    n_state = lob_pkg::S_OUT_START;
                end else begin
                    n_state = lob_pkg::S_WRITE;
                end
            end
            lob_pkg::S_WRITE: begin
                ram_we  = 1'b1;
                n_state = lob_pkg::S_OUT_START;
            end
            lob_pkg::S_OUT_START: begin
                n_state = lob_pkg::S_LAUNCH;
            end
            lob_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = lob_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lob_pkg::S_IDLE;
            end
        endcase
    end

    // Scan address, read pipeline flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == lob_pkg::S_SCAN);
            if ((r_state == lob_pkg::S_CLEAR) || (r_state == lob_pkg::S_SCAN)) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
            end
            if ((r_state == lob_pkg::S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Word capture, scan results and the sequence of level operations.
    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr;

        if (r_pend) begin
            if (rd.valid && (rd.key == r_key) && !r_found) begin
                r_found     <= 1'b1;
                r_midx      <= r_pidx;
                r_old_price <= rd.price;
                r_old_qty   <= rd.qty;
            end
            if (!rd.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_fidx       <= r_pidx;
            end
        end

        if ((r_state == lob_pkg::S_WAIT) && w_last.go) begin
            r_res <= w_last;
        end

        case (r_state)
            lob_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_cmd        <= lob_pkg::t_cmd'(i_command);
                    r_key        <= i_order_key;
                    r_price      <= i_price;
                    r_qty        <= i_quantity;
                    r_side       <= i_side;
                    r_status     <= lob_pkg::ST_OK;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                end
            end
            lob_pkg::S_DECIDE: begin
                if (r_cmd == lob_pkg::CMD_CANCEL) begin
                    r_lp    <= r_price;
                    r_ld    <= 33'sd0 - $signed({1'b0, r_qty});
                    r_phase <= lob_pkg::PH_CANCEL;
                end else if (dec_add) begin
                    if (dec_full) begin
                        r_status <= lob_pkg::ST_ORDER_FULL;
                    end else begin
                        r_slot  <= r_found ? r_midx : r_fidx;
                        r_lp    <= r_price;
                        r_ld    <= $signed({1'b0, r_qty});
                        r_phase <= lob_pkg::PH_ADD;
                    end
                end else if (r_cmd == lob_pkg::CMD_MODIFY) begin
                    // Known id: look up the new price first.
                    r_wop    <= lob_pkg::WOP_PROBE;
                    r_wprice <= r_price;
                    r_wside  <= r_side;
                    r_ret    <= lob_pkg::S_PC1_RET;
                end
            end
            lob_pkg::S_PC1_RET: begin
                r_hn     <= r_res.hit;
                r_fr     <= r_res.free;
                r_wprice <= r_old_price;
                r_ret    <= lob_pkg::S_PC2_RET;
            end
            lob_pkg::S_PC2_RET: begin
                if (mod_fail) begin
                    r_status <= lob_pkg::ST_LEVEL_FULL;
                end else begin
                    r_lp    <= r_old_price;
                    r_ld    <= 33'sd0 - $signed({1'b0, r_old_qty});
                    r_phase <= lob_pkg::PH_MOD_SUB;
                end
            end
            lob_pkg::S_LA_START: begin
                r_wop    <= lob_pkg::WOP_PROBE;
                r_wprice <= r_lp;
                r_wside  <= r_side;
                r_ret    <= lob_pkg::S_LA_PROBED;
            end
            lob_pkg::S_LA_PROBED: begin
                if (r_res.hit) begin
                    r_wop   <= lob_pkg::WOP_SET;
                    r_wvol  <= la_satv;
                    r_wkill <= la_kill;
                    r_ret   <= lob_pkg::S_LA_FIN;
                end else if (ld_pos && r_res.free) begin
                    r_wop   <= lob_pkg::WOP_ALLOC;
                    r_wvol  <= $signed({15'b0, r_ld});
                    r_wkill <= 1'b0;
                    r_ret   <= lob_pkg::S_LA_FIN;
                end else if (ld_pos) begin
                    r_status <= lob_pkg::ST_LEVEL_FULL;
                end
            end
            lob_pkg::S_LA_FIN: begin
                case (r_phase)
                    lob_pkg::PH_MOD_SUB: begin
                        r_lp    <= r_price;
                        r_ld    <= $signed({1'b0, r_qty});
                        r_phase <= lob_pkg::PH_MOD_ADD;
                    end
                    lob_pkg::PH_ADD: begin
                        r_wr_addr <= r_slot;
                        r_wr_data <= '{valid: 1'b1, key: r_key, price: r_price, qty: r_qty};
                    end
                    lob_pkg::PH_CANCEL: begin
                        r_wr_addr <= r_midx;
                        r_wr_data <= '0;
                    end
                    default: begin
                        r_wr_addr <= r_midx;
                        r_wr_data <= '{valid: 1'b1, key: r_key, price: r_price, qty: r_qty};
                    end
                endcase
            end
            lob_pkg::S_OUT_START: begin
                r_wop    <= lob_pkg::WOP_PROBE;
                r_wprice <= r_price;
                r_wside  <= r_side;
                r_ret    <= lob_pkg::S_DONE;
            end
            lob_pkg::S_DONE: begin
                if (out_free) begin
                    r_o_bb     <= r_res.have_bid ? r_res.top_bid : 32'sd0;
                    r_o_ba     <= r_res.have_ask ? r_res.low_ask : 32'sd0;
                    r_o_vol    <= r_res.hit ? r_res.vol : 48'sd0;
                    r_o_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall       = (r_state != lob_pkg::S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_best_bid_price = r_o_bb;
    assign o_best_ask_price = r_o_ba;
    assign o_level_volume   = r_o_vol;
    assign o_status         = r_o_status;

endmodule

>>> design/lob_ram.sv
// ----------------------------------------------------------------------------
// lob_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lob_level_cell.sv
// ----------------------------------------------------------------------------
// lob_level_cell: one bid level and one ask level of the level tables
// Acts on the broadcast operation when the wave reaches it, and folds its own
// levels into the best prices, lookup result and free-slot flag of the wave.
// ----------------------------------------------------------------------------
module lob_level_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lob_pkg::t_lv_cmd i_cmd,
    input  lob_pkg::t_wave   i_wave,
    output lob_pkg::t_wave   o_wave
);

    logic               r_bid_v;
    logic signed [31:0] r_bid_p;
    logic signed [47:0] r_bid_vol;
    logic               r_ask_v;
    logic signed [31:0] r_ask_p;
    logic signed [47:0] r_ask_vol;
    logic               r_go;
    lob_pkg::t_wave     r_wave;
    lob_pkg::t_wave     n_wave;

    logic               sel_v;
    logic signed [31:0] sel_p;
    logic signed [47:0] sel_vol;
    logic               match;
    logic               take;
    logic               set;

    // Level of the side that the current operation addresses.
    always_comb begin
        sel_v   = (i_cmd.side == lob_pkg::SIDE_BID) ? r_bid_v   : r_ask_v;
        sel_p   = (i_cmd.side == lob_pkg::SIDE_BID) ? r_bid_p   : r_ask_p;
        sel_vol = (i_cmd.side == lob_pkg::SIDE_BID) ? r_bid_vol : r_ask_vol;
        match   = sel_v && (sel_p == i_cmd.price);
        take    = i_wave.go && (i_cmd.op == lob_pkg::WOP_ALLOC) && i_wave.claim && !sel_v;
        set     = i_wave.go && (i_cmd.op == lob_pkg::WOP_SET) && match;
    end

    // Fold this cell into the passing word.
    always_comb begin
        n_wave       = i_wave;
        n_wave.claim = i_wave.claim && !take;
        if (r_bid_v && (!i_wave.have_bid || (r_bid_p > i_wave.top_bid))) begin
            n_wave.have_bid = 1'b1;
            n_wave.top_bid  = r_bid_p;
        end
        if (r_ask_v && (!i_wave.have_ask || (r_ask_p < i_wave.low_ask))) begin
            n_wave.have_ask = 1'b1;
            n_wave.low_ask  = r_ask_p;
        end
        n_wave.hit  = i_wave.hit || match;
        n_wave.vol  = match ? sel_vol : i_wave.vol;
        n_wave.free = i_wave.free || !sel_v;
    end

    // Valid bits and the wave's go bit are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_v <= 1'b0;
            r_ask_v <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= n_wave.go;
            if (i_cmd.side == lob_pkg::SIDE_BID) begin
                if (take) begin
                    r_bid_v <= 1'b1;
                end else if (set && i_cmd.kill) begin
                    r_bid_v <= 1'b0;
                end
            end else begin
                if (take) begin
                    r_ask_v <= 1'b1;
                end else if (set && i_cmd.kill) begin
                    r_ask_v <= 1'b0;
                end
            end
        end
    end

    // Level payload and the rest of the wave word.
    always_ff @(posedge i_clk) begin
        r_wave <= n_wave;
        if (i_cmd.side == lob_pkg::SIDE_BID) begin
            if (take) begin
                r_bid_p   <= i_cmd.price;
                r_bid_vol <= i_cmd.vol;
            end else if (set && !i_cmd.kill) begin
                r_bid_vol <= i_cmd.vol;
            end
        end else begin
            if (take) begin
                r_ask_p   <= i_cmd.price;
                r_ask_vol <= i_cmd.vol;
            end else if (set && !i_cmd.kill) begin
                r_ask_vol <= i_cmd.vol;
            end
        end
    end

    // Outgoing word with the reset go bit.
    always_comb begin
        o_wave    = r_wave;
        o_wave.go = r_go;
    end

endmodule
